### sv/urf_pkg.sv
package urf_pkg;

    localparam int RING_DEPTH    = 64;
    localparam int PTR_W         = $clog2(RING_DEPTH);
    localparam int COUNTER_WIDTH = 16;
    localparam int READ_W        = 6;
    localparam int N_W           = (PTR_W > READ_W) ? PTR_W : READ_W;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_LINE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_FLUSH = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_BAD_FRAME = 3'd2,
        ST_DATA      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FLUSHED   = 3'd5
    } status_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  rx_byte;
        logic        bad_frame;
        logic [5:0]  read_count;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  read_data;
        logic [5:0]  fill_level;
        logic [15:0] ok_total;
        logic [15:0] dropped_total;
        logic [15:0] bad_frame_total;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic              stream;
        logic              store;
        status_t           status;
        logic [7:0]        data;
        logic [PTR_W-1:0]  addr;
        logic [5:0]        count;
        logic [5:0]        fill_level;
        logic [15:0]       ok_total;
        logic [15:0]       dropped_total;
        logic [15:0]       bad_frame_total;
    } job_t;

    function automatic logic [PTR_W-1:0] held_bytes(input logic [PTR_W-1:0] w,
                                                    input logic [PTR_W-1:0] r);
        logic [PTR_W:0] diff;
        diff = {1'b0, w} - {1'b0, r};
        if (w < r)
        begin
            diff = diff + (PTR_W+1)'(RING_DEPTH);
        end
        return diff[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(RING_DEPTH - 1))
        begin
            q = '0;
        end
        else
        begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

endpackage

### sv/uart_rx_ring_fifo_with_stats.sv
// a line, flush or empty word passes the job queue and is then registered on the result side
// read and peek: the first byte passes the job queue, the ring read register and the result
// register, then one byte per cycle while pop is held; the ring's one read port sets that pace
// input words are taken every cycle while the 4-entry job queue has room
// reset clears pointers, counters, the job queue and the result valid flag; ring bytes are kept
module uart_rx_ring_fifo_with_stats (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  urf_pkg::in_word_t  item,
    input  logic               pop,
    output logic               empty,
    output urf_pkg::out_word_t result
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    urf_pkg::job_t q_din;
    urf_pkg::job_t q_dout;

    urf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .job_push (q_push),
        .job      (q_din),
        .job_full (q_full)
    );

    urf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .din   (q_din),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (q_dout)
    );

    urf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_dout),
        .job_empty (q_empty),
        .job_pop   (q_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

### sv/urf_front.sv
module urf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  urf_pkg::in_word_t item,
    output logic             job_push,
    output urf_pkg::job_t    job,
    input  logic             job_full
);

    logic [urf_pkg::PTR_W-1:0]         wptr_reg, wptr_next;
    logic [urf_pkg::PTR_W-1:0]         rptr_reg, rptr_next;
    logic [urf_pkg::COUNTER_WIDTH-1:0] ok_reg, ok_next;
    logic [urf_pkg::COUNTER_WIDTH-1:0] drop_reg, drop_next;
    logic [urf_pkg::COUNTER_WIDTH-1:0] ferr_reg, ferr_next;

    logic                      accept;
    logic [urf_pkg::PTR_W-1:0] held;
    logic [urf_pkg::PTR_W-1:0] wnext;
    logic [urf_pkg::N_W-1:0]   held_ext;
    logic [urf_pkg::N_W-1:0]   want_ext;
    logic [5:0]                n;
    logic [urf_pkg::PTR_W:0]   rsum;
    logic [urf_pkg::PTR_W-1:0] radv;

    assign full     = job_full;
    assign accept   = push && !job_full;
    assign job_push = accept;

    always_comb
    begin
        held     = urf_pkg::held_bytes(wptr_reg, rptr_reg);
        wnext    = urf_pkg::ptr_inc(wptr_reg);
        held_ext = urf_pkg::N_W'(held);
        want_ext = urf_pkg::N_W'(item.read_count);
        n        = (held_ext < want_ext) ? 6'(held_ext) : 6'(want_ext);
        rsum     = {1'b0, rptr_reg} + (urf_pkg::PTR_W+1)'(n);
        if (rsum >= (urf_pkg::PTR_W+1)'(urf_pkg::RING_DEPTH))
        begin
            rsum = rsum - (urf_pkg::PTR_W+1)'(urf_pkg::RING_DEPTH);
        end
        radv = rsum[urf_pkg::PTR_W-1:0];

        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        ok_next    = ok_reg;
        drop_next  = drop_reg;
        ferr_next  = ferr_reg;
        job.stream = 1'b0;
        job.store  = 1'b0;
        job.status = urf_pkg::ST_EMPTY;
        job.data   = item.rx_byte;
        job.addr   = wptr_reg;
        job.count  = n;

        if (accept)
        begin
            case (item.mode)
                urf_pkg::MODE_LINE:
                begin
                    if (item.bad_frame)
                    begin
                        ferr_next  = ferr_reg + urf_pkg::COUNTER_WIDTH'(1);
                        job.status = urf_pkg::ST_BAD_FRAME;
                    end
                    else if (wnext != rptr_reg)
                    begin
                        wptr_next  = wnext;
                        ok_next    = ok_reg + urf_pkg::COUNTER_WIDTH'(1);
                        job.store  = 1'b1;
                        job.status = urf_pkg::ST_STORED;
                    end
                    else
                    begin
                        drop_next  = drop_reg + urf_pkg::COUNTER_WIDTH'(1);
                        job.status = urf_pkg::ST_DROPPED;
                    end
                end
                urf_pkg::MODE_READ, urf_pkg::MODE_PEEK:
                begin
                    if (n != 6'd0)
                    begin
                        job.stream = 1'b1;
                        job.status = urf_pkg::ST_DATA;
                        job.addr   = rptr_reg;
                        if (item.mode == urf_pkg::MODE_READ)
                        begin
                            rptr_next = radv;
                        end
                    end
                end
                urf_pkg::MODE_FLUSH:
                begin
                    wptr_next  = '0;
                    rptr_next  = '0;
                    job.status = urf_pkg::ST_FLUSHED;
                end
                default:
                begin
                    job.status = urf_pkg::ST_EMPTY;
                end
            endcase
        end

        job.fill_level      = 6'(urf_pkg::held_bytes(wptr_next, rptr_next));
        job.ok_total        = 16'(ok_next);
        job.dropped_total   = 16'(drop_next);
        job.bad_frame_total = 16'(ferr_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            ok_reg   <= '0;
            drop_reg <= '0;
            ferr_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            ok_reg   <= ok_next;
            drop_reg <= drop_next;
            ferr_reg <= ferr_next;
        end
    end

endmodule

### sv/urf_queue.sv
module urf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  urf_pkg::job_t din,
    input  logic          pop,
    output logic          empty,
    output urf_pkg::job_t dout
);

    urf_pkg::job_t slot_reg [urf_pkg::QUEUE_DEPTH];

    logic [urf_pkg::QPTR_W-1:0] wr_reg, wr_next;
    logic [urf_pkg::QPTR_W-1:0] rd_reg, rd_next;
    logic [urf_pkg::QPTR_W:0]   cnt_reg, cnt_next;
    logic                       do_push;
    logic                       do_pop;

    assign full    = (cnt_reg == (urf_pkg::QPTR_W+1)'(urf_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + urf_pkg::QPTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + urf_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + (urf_pkg::QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - (urf_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### sv/urf_back.sv
module urf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  urf_pkg::job_t      job,
    input  logic               job_empty,
    output logic               job_pop,
    output urf_pkg::out_word_t result,
    output logic               empty,
    input  logic               pop
);

    logic [7:0] ring [urf_pkg::RING_DEPTH];

    logic                      out_valid_reg, out_valid_next;
    urf_pkg::out_word_t        out_reg, out_next;
    logic                      busy_reg, busy_next;
    logic                      pend_reg, pend_next;
    logic                      pend_last_reg, pend_last_next;
    urf_pkg::job_t             cur_reg, cur_next;
    logic [urf_pkg::PTR_W-1:0] raddr_reg, raddr_next;
    logic [5:0]                left_reg, left_next;
    logic [7:0]                rdata_reg;

    logic out_load;
    logic pend_go;
    logic issue;
    logic take;

    assign result  = out_reg;
    assign empty   = !out_valid_reg;
    assign job_pop = take;

    always_comb
    begin
        out_load = !out_valid_reg || pop;
        pend_go  = pend_reg && out_load;
        issue    = busy_reg && (!pend_reg || pend_go);
        take     = !job_empty && !busy_reg && !pend_reg && (job.stream || out_load);

        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        busy_next      = busy_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        cur_next       = cur_reg;
        raddr_next     = raddr_reg;
        left_next      = left_reg;

        if (pend_go)
        begin
            out_next.status          = urf_pkg::ST_DATA;
            out_next.read_data       = rdata_reg;
            out_next.fill_level      = cur_reg.fill_level;
            out_next.ok_total        = cur_reg.ok_total;
            out_next.dropped_total   = cur_reg.dropped_total;
            out_next.bad_frame_total = cur_reg.bad_frame_total;
            out_next.last            = pend_last_reg;
            out_valid_next           = 1'b1;
            pend_next                = 1'b0;
        end
        else if (take && !job.stream)
        begin
            out_next.status          = job.status;
            out_next.read_data       = 8'd0;
            out_next.fill_level      = job.fill_level;
            out_next.ok_total        = job.ok_total;
            out_next.dropped_total   = job.dropped_total;
            out_next.bad_frame_total = job.bad_frame_total;
            out_next.last            = 1'b1;
            out_valid_next           = 1'b1;
        end

        if (take && job.stream)
        begin
            busy_next  = 1'b1;
            cur_next   = job;
            raddr_next = job.addr;
            left_next  = job.count;
        end

        if (issue)
        begin
            pend_next      = 1'b1;
            pend_last_next = (left_reg == 6'd1);
            raddr_next     = urf_pkg::ptr_inc(raddr_reg);
            left_next      = left_reg - 6'd1;
            if (left_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && job.store)
        begin
            ring[job.addr] <= job.data;
        end
        if (issue)
        begin
            rdata_reg <= ring[raddr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        cur_reg   <= cur_next;
        raddr_reg <= raddr_next;
        left_reg  <= left_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

endmodule

### sv/urf_checker.sv
module urf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input urf_pkg::in_word_t  item,
    input logic               pop,
    input logic               empty,
    input urf_pkg::out_word_t result
);

    // a waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while stalled");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.status != urf_pkg::ST_DATA |-> result.last && result.read_data == 8'd0)
        else $error("non-data word not final or carries data");

    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.status == urf_pkg::ST_FLUSHED |-> result.fill_level == 6'd0)
        else $error("flush word with nonzero fill level");

    // a data burst continues with data words only
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !result.last |=> empty || result.status == urf_pkg::ST_DATA)
        else $error("data burst broken by another word");

endmodule

bind uart_rx_ring_fifo_with_stats urf_checker u_urf_checker (.*);
